// ===== rtl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 64;
    localparam int TAG_W    = 16;
    localparam int FUNC_W   = 2;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_PEEK   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_SET_FULL,
        OP_SET_EMPTY,
        OP_INS_SETUP,
        OP_RD_ROOT,
        OP_DEL_SETUP,
        OP_UP_READ,
        OP_UP_MOVE,
        OP_DN_READ,
        OP_DN_MOVE,
        OP_WRITE_ITEM,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_insert;
        logic is_remove;
        logic is_delete;
        logic full;
        logic empty;
        logic last_one;
        logic at_root;
        logic parent_le;
        logic no_child;
        logic best_is_pos;
    } dp_sts_t;

endpackage

// ===== rtl/binary_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Fixed-capacity min-heap priority queue with insert, delete-min and peek.
// ----------------------------------------------------------------------------
// One transfer is worked on at a time, with one read and one compare per heap
// level on the single entry memory. An insert is decoded, climbs through
// parent reads and compares, and writes the new entry; a delete-min reads the
// root and the last entry, then sinks the moved entry through child reads and
// compares; a peek reads the root; an operation flagged full or empty goes
// straight to the result. With 64 entries the worst case is an insert that
// climbs 6 levels. A finished result sits in an output register, so the next
// transfer is taken while the previous result is still stalled. Ties end the
// sift, leaving the moving entry where it stands, and between children favor
// the left one.
module binary_min_heap_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [bmhq_pkg::FUNC_W-1:0]    func,
    input  logic [bmhq_pkg::KEY_W-1:0]     priority_req,
    input  logic [bmhq_pkg::TAG_W-1:0]     node_tag,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bmhq_pkg::TAG_W-1:0]     out_tag,
    output logic [bmhq_pkg::KEY_W-1:0]     out_priority,
    output logic [bmhq_pkg::STAT_W-1:0]    status,
    output logic [bmhq_pkg::CNT_W-1:0]     count
);

    bmhq_pkg::dp_cmd_t cmd;
    bmhq_pkg::dp_sts_t sts;

    bmhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bmhq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .func         (func),
        .priority_req (priority_req),
        .node_tag     (node_tag),
        .out_tag      (out_tag),
        .out_priority (out_priority),
        .status       (status),
        .count        (count)
    );

endmodule

// ===== rtl/bmhq_dp.sv =====
// ----------------------------------------------------------------------------
// bmhq_dp
// Heap datapath: entry memory, moving-entry and position registers, entry
// count, key compares and the output register.
// ----------------------------------------------------------------------------
module bmhq_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bmhq_pkg::dp_cmd_t              cmd,
    output bmhq_pkg::dp_sts_t              sts,
    input  logic [bmhq_pkg::FUNC_W-1:0]    func,
    input  logic [bmhq_pkg::KEY_W-1:0]     priority_req,
    input  logic [bmhq_pkg::TAG_W-1:0]     node_tag,
    output logic [bmhq_pkg::TAG_W-1:0]     out_tag,
    output logic [bmhq_pkg::KEY_W-1:0]     out_priority,
    output logic [bmhq_pkg::STAT_W-1:0]    status,
    output logic [bmhq_pkg::CNT_W-1:0]     count
);

    localparam int CW = bmhq_pkg::CNT_W;
    localparam int AW = bmhq_pkg::ADDR_W;
    localparam int LW = bmhq_pkg::CNT_W + 1;

    bmhq_pkg::entry_t mem [bmhq_pkg::CAPACITY];
    bmhq_pkg::entry_t rd_a_reg;
    bmhq_pkg::entry_t rd_b_reg;
    bmhq_pkg::entry_t item_reg, item_next;
    bmhq_pkg::entry_t wr_data;
    bmhq_pkg::entry_t res_reg, res_next;

    logic [bmhq_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [bmhq_pkg::STAT_W-1:0] stat_reg, stat_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               pos_reg, pos_next;

    logic [bmhq_pkg::TAG_W-1:0]  out_tag_reg;
    logic [bmhq_pkg::KEY_W-1:0]  out_pri_reg;
    logic [bmhq_pkg::STAT_W-1:0] out_stat_reg;
    logic [CW-1:0]               out_cnt_reg;

    logic [CW-1:0] pos_m1;
    logic [CW-1:0] par;
    logic [CW-1:0] par_m1;
    logic [CW-1:0] cnt_m1;
    logic [LW-1:0] lc;
    logic [LW-1:0] rc;
    logic [LW-1:0] lc_m1;
    logic [LW-1:0] cnt_ext;
    logic          take_l;
    logic          take_r;
    logic [bmhq_pkg::KEY_W-1:0] best_key;

    logic          wr_en;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;

    assign pos_m1  = pos_reg - CW'(1);
    assign par     = pos_reg >> 1;
    assign par_m1  = par - CW'(1);
    assign cnt_m1  = count_reg - CW'(1);
    assign lc      = {pos_reg, 1'b0};
    assign rc      = lc + LW'(1);
    assign lc_m1   = lc - LW'(1);
    assign cnt_ext = {1'b0, count_reg};

    assign take_l   = (lc <= cnt_ext) && (rd_a_reg.key < item_reg.key);
    assign best_key = take_l ? rd_a_reg.key : item_reg.key;
    assign take_r   = (rc <= cnt_ext) && (rd_b_reg.key < best_key);

    always_comb
    begin
        sts.is_insert   = (func_reg == bmhq_pkg::FN_INSERT);
        sts.is_remove   = (func_reg == bmhq_pkg::FN_DELETE) ||
                          (func_reg == bmhq_pkg::FN_PEEK);
        sts.is_delete   = (func_reg == bmhq_pkg::FN_DELETE);
        sts.full        = (count_reg >= CW'(bmhq_pkg::CAPACITY));
        sts.empty       = (count_reg == '0);
        sts.last_one    = (count_reg == CW'(1));
        sts.at_root     = (pos_reg == CW'(1));
        sts.parent_le   = (rd_a_reg.key <= item_reg.key);
        sts.no_child    = (lc > cnt_ext);
        sts.best_is_pos = !take_l && !take_r;
    end

    always_comb
    begin
        item_next  = item_reg;
        res_next   = res_reg;
        func_next  = func_reg;
        stat_next  = stat_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        wr_en      = 1'b0;
        wr_data    = item_reg;
        rd_a_addr  = '0;
        rd_b_addr  = '0;
        unique case (cmd.op)
            bmhq_pkg::OP_LATCH:
            begin
                func_next    = func;
                item_next    = '{key: priority_req, tag: node_tag};
                res_next     = '0;
                stat_next    = bmhq_pkg::ST_OK;
            end
            bmhq_pkg::OP_SET_FULL:
            begin
                stat_next = bmhq_pkg::ST_FULL;
            end
            bmhq_pkg::OP_SET_EMPTY:
            begin
                stat_next = bmhq_pkg::ST_EMPTY;
            end
            bmhq_pkg::OP_INS_SETUP:
            begin
                count_next = count_reg + CW'(1);
                pos_next   = count_reg + CW'(1);
            end
            bmhq_pkg::OP_RD_ROOT:
            begin
                rd_a_addr = '0;
                rd_b_addr = cnt_m1[AW-1:0];
            end
            bmhq_pkg::OP_DEL_SETUP:
            begin
                res_next = rd_a_reg;
                if (sts.is_delete)
                begin
                    item_next  = rd_b_reg;
                    count_next = cnt_m1;
                    pos_next   = CW'(1);
                end
            end
            bmhq_pkg::OP_UP_READ:
            begin
                rd_a_addr = par_m1[AW-1:0];
            end
            bmhq_pkg::OP_UP_MOVE:
            begin
                wr_en    = 1'b1;
                wr_data  = rd_a_reg;
                pos_next = par;
            end
            bmhq_pkg::OP_DN_READ:
            begin
                rd_a_addr = lc_m1[AW-1:0];
                rd_b_addr = lc[AW-1:0];
            end
            bmhq_pkg::OP_DN_MOVE:
            begin
                wr_en    = 1'b1;
                wr_data  = take_r ? rd_b_reg : rd_a_reg;
                pos_next = take_r ? rc[CW-1:0] : lc[CW-1:0];
            end
            bmhq_pkg::OP_WRITE_ITEM:
            begin
                wr_en   = 1'b1;
                wr_data = item_reg;
            end
            bmhq_pkg::OP_NONE,
            bmhq_pkg::OP_LOAD_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_m1[AW-1:0]] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        func_reg <= func_next;
        stat_reg <= stat_next;
        pos_reg  <= pos_next;
        if (cmd.op == bmhq_pkg::OP_LOAD_OUT)
        begin
            out_tag_reg  <= res_reg.tag;
            out_pri_reg  <= res_reg.key;
            out_stat_reg <= stat_reg;
            out_cnt_reg  <= count_reg;
        end
    end

    assign out_tag      = out_tag_reg;
    assign out_priority = out_pri_reg;
    assign status       = out_stat_reg;
    assign count        = out_cnt_reg;

endmodule

// ===== rtl/bmhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for the heap queue: decodes a transfer, steps the sift up or
// sift down one level per compare, and owns both handshakes.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  bmhq_pkg::dp_sts_t  sts,
    output bmhq_pkg::dp_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DECODE  = 8'b0000_0010,
        S_DEL_SET = 8'b0000_0100,
        S_UP_RD   = 8'b0000_1000,
        S_UP_CMP  = 8'b0001_0000,
        S_DN_RD   = 8'b0010_0000,
        S_DN_CMP  = 8'b0100_0000,
        S_RESP    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   load_out;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = bmhq_pkg::OP_NONE;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = bmhq_pkg::OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (sts.is_insert)
                begin
                    if (sts.full)
                    begin
                        cmd.op     = bmhq_pkg::OP_SET_FULL;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.op     = bmhq_pkg::OP_INS_SETUP;
                        state_next = S_UP_RD;
                    end
                end
                else if (sts.is_remove)
                begin
                    if (sts.empty)
                    begin
                        cmd.op     = bmhq_pkg::OP_SET_EMPTY;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.op     = bmhq_pkg::OP_RD_ROOT;
                        state_next = S_DEL_SET;
                    end
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_DEL_SET:
            begin
                cmd.op = bmhq_pkg::OP_DEL_SETUP;
                if (sts.is_delete && !sts.last_one)
                begin
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_UP_RD:
            begin
                if (sts.at_root)
                begin
                    cmd.op     = bmhq_pkg::OP_WRITE_ITEM;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op     = bmhq_pkg::OP_UP_READ;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (sts.parent_le)
                begin
                    cmd.op     = bmhq_pkg::OP_WRITE_ITEM;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op     = bmhq_pkg::OP_UP_MOVE;
                    state_next = S_UP_RD;
                end
            end
            S_DN_RD:
            begin
                if (sts.no_child)
                begin
                    cmd.op     = bmhq_pkg::OP_WRITE_ITEM;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op     = bmhq_pkg::OP_DN_READ;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (sts.best_is_pos)
                begin
                    cmd.op     = bmhq_pkg::OP_WRITE_ITEM;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op     = bmhq_pkg::OP_DN_MOVE;
                    state_next = S_DN_RD;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op     = bmhq_pkg::OP_LOAD_OUT;
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_DECODE)
        else $error("accepted transfer did not enter decode");

    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result appeared outside the response step");

    a_resp_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESP && out_valid_reg && out_stall |=> state_reg == S_RESP)
        else $error("result dropped while output register was occupied");

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UP_CMP || state_reg == S_DN_CMP |->
        $past(state_reg == S_UP_RD) || $past(state_reg == S_DN_RD))
        else $error("compare step without a preceding memory read");

endmodule

// ===== test/binary_min_heap_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue testbench
// Drives insert, delete-min, peek and unused-selector transfers into the heap
// queue under random sender gaps and receiver stalls, predicts every result
// with an independent heap model and checks each returned field in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [bmhq_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 40;

    typedef struct packed {
        logic                        sync_point;
        logic [bmhq_pkg::FUNC_W-1:0] fn;
        logic [bmhq_pkg::KEY_W-1:0]  key;
        logic [bmhq_pkg::TAG_W-1:0]  tag;
    } heap_req_t;

    typedef struct packed {
        logic [bmhq_pkg::TAG_W-1:0]  tag;
        logic [bmhq_pkg::KEY_W-1:0]  key;
        logic [bmhq_pkg::STAT_W-1:0] status;
        logic [bmhq_pkg::CNT_W-1:0]  cnt;
    } heap_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [bmhq_pkg::FUNC_W-1:0] func = '0;
    logic [bmhq_pkg::KEY_W-1:0]  priority_req = '0;
    logic [bmhq_pkg::TAG_W-1:0]  node_tag = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [bmhq_pkg::TAG_W-1:0]  out_tag;
    logic [bmhq_pkg::KEY_W-1:0]  out_priority;
    logic [bmhq_pkg::STAT_W-1:0] status;
    logic [bmhq_pkg::CNT_W-1:0]  count;

    heap_req_t    pending_reqs[$];
    heap_result_t expected_results[$];

    logic [bmhq_pkg::KEY_W-1:0] heap_key [1:bmhq_pkg::CAPACITY];
    logic [bmhq_pkg::TAG_W-1:0] heap_tag [1:bmhq_pkg::CAPACITY];
    int heap_cnt = 0;

    int send_gap_pct = 0;
    int stall_pct = 0;
    int reqs_queued = 0;
    int reqs_accepted = 0;
    int fail_count = 0;
    int idle_cycles = 0;

    logic         send_fire;
    logic         send_valid;
    heap_req_t    cur_req;
    heap_result_t seen_result;

    binary_min_heap_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .priority_req (priority_req),
        .node_tag     (node_tag),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_tag      (out_tag),
        .out_priority (out_priority),
        .status       (status),
        .count        (count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void swap_entries(input int a, input int b);
        logic [bmhq_pkg::KEY_W-1:0] k;
        logic [bmhq_pkg::TAG_W-1:0] t;
        k = heap_key[a];
        t = heap_tag[a];
        heap_key[a] = heap_key[b];
        heap_tag[a] = heap_tag[b];
        heap_key[b] = k;
        heap_tag[b] = t;
    endfunction

    function automatic void predict_heap(input logic [bmhq_pkg::FUNC_W-1:0] fn,
                                         input logic [bmhq_pkg::KEY_W-1:0] key,
                                         input logic [bmhq_pkg::TAG_W-1:0] tag);
        heap_result_t r;
        int pos;
        int best;
        int lc;
        r = '0;
        r.status = bmhq_pkg::ST_OK;
        if (fn == bmhq_pkg::FN_INSERT)
        begin
            if (heap_cnt >= bmhq_pkg::CAPACITY)
                r.status = bmhq_pkg::ST_FULL;
            else
            begin
                heap_cnt++;
                heap_key[heap_cnt] = key;
                heap_tag[heap_cnt] = tag;
                pos = heap_cnt;
                while (pos > 1 && heap_key[pos >> 1] > heap_key[pos])
                begin
                    swap_entries(pos, pos >> 1);
                    pos = pos >> 1;
                end
            end
        end
        else if (fn == bmhq_pkg::FN_DELETE || fn == bmhq_pkg::FN_PEEK)
        begin
            if (heap_cnt == 0)
                r.status = bmhq_pkg::ST_EMPTY;
            else
            begin
                r.tag = heap_tag[1];
                r.key = heap_key[1];
                if (fn == bmhq_pkg::FN_DELETE)
                begin
                    heap_key[1] = heap_key[heap_cnt];
                    heap_tag[1] = heap_tag[heap_cnt];
                    heap_cnt--;
                    pos = 1;
                    best = 0;
                    while (best != pos)
                    begin
                        best = pos;
                        lc = 2 * pos;
                        if (lc <= heap_cnt && heap_key[lc] < heap_key[best])
                            best = lc;
                        if (lc + 1 <= heap_cnt && heap_key[lc + 1] < heap_key[best])
                            best = lc + 1;
                        if (best != pos)
                        begin
                            swap_entries(pos, best);
                            pos = best;
                            best = 0;
                        end
                    end
                end
            end
        end
        r.cnt = heap_cnt[bmhq_pkg::CNT_W-1:0];
        expected_results.push_back(r);
    endfunction

    function automatic logic [bmhq_pkg::KEY_W-1:0] rand_key();
        case ($urandom_range(0, 3))
            0: return 64'($urandom_range(0, 7));
            1: return {$urandom, $urandom};
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return {1'b1, 63'd0};
                    default: return {1'b0, {63{1'b1}}};
                endcase
            end
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    task automatic push_req(input logic [bmhq_pkg::FUNC_W-1:0] fn,
                            input logic [bmhq_pkg::KEY_W-1:0] key,
                            input logic [bmhq_pkg::TAG_W-1:0] tag);
        heap_req_t q;
        q.sync_point = 1'b0;
        q.fn = fn;
        q.key = key;
        q.tag = tag;
        pending_reqs.push_back(q);
        reqs_queued++;
    endtask

    task automatic push_sync();
        heap_req_t q;
        q = '0;
        q.sync_point = 1'b1;
        pending_reqs.push_back(q);
    endtask

    task automatic add_burst(input int ins_pct, input int len);
        int roll;
        logic [bmhq_pkg::FUNC_W-1:0] fn;
        for (int i = 0; i < len; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll == 0)
                fn = FN_UNUSED;
            else if (roll <= ins_pct)
                fn = bmhq_pkg::FN_INSERT;
            else if (roll <= ins_pct + (100 - ins_pct) / 4)
                fn = bmhq_pkg::FN_PEEK;
            else
                fn = bmhq_pkg::FN_DELETE;
            push_req(fn, rand_key(), bmhq_pkg::TAG_W'($urandom_range(0, 65535)));
        end
    endtask

    task automatic add_random(input int total);
        int left;
        int len;
        left = total;
        while (left > 0)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    len = 80;
                    add_burst(95, len);
                end
                1:
                begin
                    len = 100;
                    add_burst(5, len);
                end
                default:
                begin
                    len = $urandom_range(5, 40);
                    add_burst($urandom_range(35, 65), len);
                end
            endcase
            left -= len;
        end
    endtask

    task automatic wait_queue_drained();
        while (pending_reqs.size() > 0)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            send_fire = in_valid && !in_stall;
            if (send_fire)
            begin
                predict_heap(func, priority_req, node_tag);
                reqs_accepted++;
            end
            send_valid = in_valid && !send_fire;
            if (!send_valid && pending_reqs.size() > 0)
            begin
                if (pending_reqs[0].sync_point)
                begin
                    if (expected_results.size() == 0)
                        void'(pending_reqs.pop_front());
                end
                else if ($urandom_range(0, 99) >= send_gap_pct)
                begin
                    cur_req = pending_reqs.pop_front();
                    send_valid = 1'b1;
                    func <= cur_req.fn;
                    priority_req <= cur_req.key;
                    node_tag <= cur_req.tag;
                end
            end
            in_valid <= send_valid;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic check_field(input string name, input logic [bmhq_pkg::KEY_W-1:0] want,
                               input logic [bmhq_pkg::KEY_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected transfer expected none actual tag %h pri %h st %0d cnt %0d",
                         $time, out_tag, out_priority, status, count);
                fail_count++;
            end
            else
            begin
                seen_result = expected_results.pop_front();
                check_field("out_tag", bmhq_pkg::KEY_W'(seen_result.tag),
                            bmhq_pkg::KEY_W'(out_tag));
                check_field("out_priority", seen_result.key, out_priority);
                check_field("status", bmhq_pkg::KEY_W'(seen_result.status),
                            bmhq_pkg::KEY_W'(status));
                check_field("count", bmhq_pkg::KEY_W'(seen_result.cnt),
                            bmhq_pkg::KEY_W'(count));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        send_gap_pct = 23;
        stall_pct = 46;

        // empty queue, ties, key extremes, unused selector
        push_req(bmhq_pkg::FN_PEEK, '0, '0);
        push_req(bmhq_pkg::FN_DELETE, '1, '1);
        push_req(FN_UNUSED, '1, '1);
        push_req(bmhq_pkg::FN_INSERT, 64'd5, 16'h1111);
        push_req(bmhq_pkg::FN_INSERT, '1, 16'hffff);
        push_req(bmhq_pkg::FN_INSERT, '0, 16'h0000);
        push_req(bmhq_pkg::FN_INSERT, 64'd5, 16'h2222);
        push_req(bmhq_pkg::FN_INSERT, 64'd5, 16'h3333);
        push_req(bmhq_pkg::FN_PEEK, '0, '0);
        push_req(FN_UNUSED, 64'd1, 16'h0001);
        push_req(bmhq_pkg::FN_INSERT, '1, 16'haaaa);
        push_req(bmhq_pkg::FN_INSERT, {1'b1, 63'd0}, 16'h5555);
        for (int i = 0; i < 8; i++)
            push_req(bmhq_pkg::FN_DELETE, '0, '0);
        push_req(bmhq_pkg::FN_PEEK, '1, '1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // fill past capacity, then drain past empty
        add_burst(100, 70);
        add_burst(0, 100);
        add_random(240);
        push_sync();
        add_random(240);
        wait_queue_drained();

        send_gap_pct = 46;
        stall_pct = 23;
        add_random(240);
        push_sync();
        add_random(240);
        wait_queue_drained();

        send_gap_pct = 0;
        stall_pct = 0;
        add_random(240);
        push_sync();
        add_random(240);

        while (reqs_accepted < reqs_queued)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
